// ===== design/gas_pkg.sv =====
// Shared types and constants for the grid A* search block.
// No dependencies; compile before the interfaces and the top level.
`timescale 1ns / 1ps

package gas_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned COST_W     = 17;
  localparam int unsigned OUT_COST_W = 16;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned N_W        = 2 * DIM_W;
  // path cost plus Manhattan distance
  localparam int unsigned F_W        = 18;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [COST_W-1:0] COST_UNREACHED = '1;

  typedef enum logic [OP_W-1:0] {
    OP_WALL = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_NO_PATH = 2'd1,
    ST_INVALID = 2'd2,
    ST_COST    = 2'd3
  } status_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

endpackage

// ===== design/gas_intf.sv =====
// Valid/ready channel interfaces for the grid A* search block.
// Depends on gas_pkg for the field widths.
`timescale 1ns / 1ps

interface gas_in_if;
  import gas_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [IDX_W-1:0]     cell_index;
  logic                 wall_bit;
  logic [IDX_W-1:0]     start_cell;
  logic [IDX_W-1:0]     goal_cell;

  modport source (output valid, operation, cell_index, wall_bit, start_cell, goal_cell,
                  input ready);
  modport sink (input valid, operation, cell_index, wall_bit, start_cell, goal_cell,
                output ready);
endinterface

interface gas_out_if;
  import gas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ST_W-1:0]       status;
  logic [OUT_COST_W-1:0] cost;
  logic                  reached;

  modport source (output valid, status, cost, reached, input ready);
  modport sink (input valid, status, cost, reached, output ready);
endinterface

// ===== design/grid_astar_search_top.sv =====
// Grid A* search engine: wall map, cost map and open-list heap in on-chip memories.
// Depends on gas_pkg and the channel interfaces in gas_intf.sv.
`timescale 1ns / 1ps

// The block holds a wall map of up to MAX_ROWS x MAX_COLS cells (row-major) and
// answers three transaction kinds. A wall write gives no result. A cost read
// holds the input off while it does one memory read and loads the output
// register, and returns the cell's stored cost (zero, with reached low, if the
// cell is unreached) with status 3. A run checks its arguments in order
// (dimensions, cell range, start wall, goal wall); bad dimensions, out-of-range
// cells or a walled start or goal give status 2, load the result and leave the
// cost map alone. A good run first sweeps the cost map over the rows*cols cells
// in use, one cell a cycle, then runs A* with a binary-heap open list kept in a
// single-port-read memory. The heap memory port and the cost memory port set
// the pace of the search. The input is held off for the whole run; the result
// sits in an output register, so the next transaction is taken while it waits.
// The stores come up undefined and need no clearing after reset.
module grid_astar_search_top #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gas_pkg::APB_AW-1:0]    paddr,
  input  logic [gas_pkg::APB_DW-1:0]    pwdata,
  output logic [gas_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  gas_in_if.sink                        in_i,
  gas_out_if.source                     out_o
);
  import gas_pkg::*;

  localparam int unsigned RW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CLW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned GRID_CELLS  = MAX_ROWS * MAX_COLS;
  localparam int unsigned STORE_CELLS = (GRID_CELLS > 65536) ? GRID_CELLS : 65536;
  localparam int unsigned CW          = $clog2(STORE_CELLS);
  localparam int unsigned IW          = (CW > N_W) ? CW : N_W;
  localparam int unsigned SLOTS       = 4 * STORE_CELLS + 4;
  localparam int unsigned HA          = $clog2(SLOTS);
  localparam int unsigned LW          = $clog2(SLOTS + 1);
  localparam int unsigned KW          = LW + 1;
  localparam int unsigned H_W         = ((RW > CLW) ? RW : CLW) + 1;
  localparam int unsigned DW2         = ((RW > DIM_W) ? RW : DIM_W) + 1;
  localparam int unsigned CW2         = ((CLW > DIM_W) ? CLW : DIM_W) + 1;

  // One open-list entry: the key is {f, v}; row and column ride along so that
  // no division is needed for the heuristic.
  typedef struct packed {
    logic [F_W-1:0] f;
    logic [CW-1:0]  v;
    logic [RW-1:0]  r;
    logic [CLW-1:0] c;
  } entry_t;

  typedef enum logic [1:0] {
    NB_UP    = 2'd0,
    NB_DOWN  = 2'd1,
    NB_LEFT  = 2'd2,
    NB_RIGHT = 2'd3
  } nb_e;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_CHK, S_CHK2, S_WG, S_WC, S_CLR, S_INIT,
    S_PUSH_UP, S_PUSH_CMP, S_LOOP, S_POP0, S_POP1, S_POP2, S_POP_DN,
    S_POP_K1, S_POP_K2, S_POP_CMP, S_POP_END, S_EX0, S_EX1,
    S_NB0, S_NB1, S_NEXT, S_RES
  } state_e;

  function automatic logic key_le(entry_t a, entry_t b);
    return {a.f, a.v} <= {b.f, b.v};
  endfunction

  function automatic logic key_lt(entry_t a, entry_t b);
    return {a.f, a.v} < {b.f, b.v};
  endfunction

  function automatic logic [H_W-1:0] heur(logic [RW-1:0] r, logic [CLW-1:0] c,
                                          logic [RW-1:0] gr, logic [CLW-1:0] gc);
    logic [RW-1:0]  dr;
    logic [CLW-1:0] dc;
    dr = (r > gr) ? r - gr : gr - r;
    dc = (c > gc) ? c - gc : gc - c;
    return H_W'(dr) + H_W'(dc);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
      cols_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[2]))
        REG_ROWS: rows_q <= pwdata[DIM_W-1:0];
        REG_COLS: cols_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (reg_e'(paddr[2]) == REG_COLS) ? APB_DW'(cols_q) : APB_DW'(rows_q);

  // ---------------------------------------------------------------------------
  // Memories: wall bits, {closed, cost} per cell, open-list heap
  // ---------------------------------------------------------------------------
  logic              wall_mem [STORE_CELLS];
  logic [COST_W:0]   cost_mem [STORE_CELLS];
  entry_t            heap_mem [SLOTS];

  logic              wm_we, wm_wdata, wm_re, wm_rd_q;
  logic [CW-1:0]     wm_waddr, wm_raddr;
  logic              cm_we, cm_re;
  logic [CW-1:0]     cm_waddr, cm_raddr;
  logic [COST_W:0]   cm_wdata, cm_rd_q;
  logic              hp_we, hp_re;
  logic [HA-1:0]     hp_waddr, hp_raddr;
  entry_t            hp_wdata, hp_rd_q;

  always_ff @(posedge clk_i) begin
    if (wm_we) wall_mem[wm_waddr] <= wm_wdata;
    if (wm_re) wm_rd_q <= wall_mem[wm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cm_we) cost_mem[cm_waddr] <= cm_wdata;
    if (cm_re) cm_rd_q <= cost_mem[cm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hp_we) heap_mem[hp_waddr] <= hp_wdata;
    if (hp_re) hp_rd_q <= heap_mem[hp_raddr];
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [IDX_W-1:0]      start_q, start_d, goal_q, goal_d;
  logic [IW-1:0]         n_q, n_d;
  logic [CW-1:0]         i_q, i_d;
  logic [RW-1:0]         r_q, r_d, sr_q, sr_d, gr_q, gr_d, xr_q, xr_d;
  logic [CLW-1:0]        c_q, c_d, sc_q, sc_d, gc_q, gc_d, xc_q, xc_d;
  logic [LW-1:0]         len_q, len_d, pos_q, pos_d, up_q, up_d;
  logic [KW-1:0]         kid_q, kid_d;
  entry_t                key_q, key_d, best_q, best_d, top_q, top_d, last_q, last_d;
  logic                  from_nb_q, from_nb_d;
  logic [COST_W-1:0]     g_q, g_d;
  nb_e                   nb_q, nb_d;
  logic [CW-1:0]         x_q, x_d;
  status_e               res_status_q, res_status_d, out_status_q, out_status_d;
  logic [OUT_COST_W-1:0] res_cost_q, res_cost_d, out_cost_q, out_cost_d;
  logic                  res_reached_q, res_reached_d, out_reached_q, out_reached_d;
  logic                  out_valid_q, out_valid_d;

  // helper nets
  logic [LW-1:0]     pos_m1, up_idx, len_m1;
  logic [KW-1:0]     kid_first, kid_next;
  logic              nb_ok;
  logic [CW-1:0]     nb_v;
  logic [RW-1:0]     nb_r;
  logic [CLW-1:0]    nb_c;
  logic [COST_W-1:0] g_inc;
  logic              stale;

  assign pos_m1    = pos_q - LW'(1);
  assign up_idx    = pos_m1 >> 1;
  assign len_m1    = len_q - LW'(1);
  assign kid_first = {pos_q, 1'b1};
  assign kid_next  = kid_q + KW'(1);
  assign g_inc     = g_q + COST_W'(1);

  assign stale = (IW'(top_q.v) >= n_q) || cm_rd_q[COST_W] ||
                 (top_q.f != F_W'(cm_rd_q[COST_W-1:0]) +
                             F_W'(heur(top_q.r, top_q.c, gr_q, gc_q)));

  // Neighbour of the cell being expanded, in the order up, down, left, right.
  always_comb begin
    nb_ok = 1'b0;
    nb_v  = top_q.v;
    nb_r  = top_q.r;
    nb_c  = top_q.c;
    case (nb_q)
      NB_UP: begin
        nb_ok = (top_q.r != '0);
        nb_v  = top_q.v - CW'(cols_q);
        nb_r  = top_q.r - RW'(1);
      end
      NB_DOWN: begin
        nb_ok = (DW2'(top_q.r) + DW2'(1)) < DW2'(rows_q);
        nb_v  = top_q.v + CW'(cols_q);
        nb_r  = top_q.r + RW'(1);
      end
      NB_LEFT: begin
        nb_ok = (top_q.c != '0);
        nb_v  = top_q.v - CW'(1);
        nb_c  = top_q.c - CLW'(1);
      end
      NB_RIGHT: begin
        nb_ok = (CW2'(top_q.c) + CW2'(1)) < CW2'(cols_q);
        nb_v  = top_q.v + CW'(1);
        nb_c  = top_q.c + CLW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    start_d       = start_q;
    goal_d        = goal_q;
    n_d           = n_q;
    i_d           = i_q;
    r_d           = r_q;
    c_d           = c_q;
    sr_d          = sr_q;
    sc_d          = sc_q;
    gr_d          = gr_q;
    gc_d          = gc_q;
    xr_d          = xr_q;
    xc_d          = xc_q;
    x_d           = x_q;
    len_d         = len_q;
    pos_d         = pos_q;
    up_d          = up_q;
    kid_d         = kid_q;
    key_d         = key_q;
    best_d        = best_q;
    top_d         = top_q;
    last_d        = last_q;
    from_nb_d     = from_nb_q;
    g_d           = g_q;
    nb_d          = nb_q;
    res_status_d  = res_status_q;
    res_cost_d    = res_cost_q;
    res_reached_d = res_reached_q;
    out_status_d  = out_status_q;
    out_cost_d    = out_cost_q;
    out_reached_d = out_reached_q;
    out_valid_d   = out_valid_q;

    wm_we = 1'b0; wm_waddr = '0; wm_wdata = 1'b0; wm_re = 1'b0; wm_raddr = '0;
    cm_we = 1'b0; cm_waddr = '0; cm_wdata = '0;   cm_re = 1'b0; cm_raddr = '0;
    hp_we = 1'b0; hp_waddr = '0; hp_wdata = '0;   hp_re = 1'b0; hp_raddr = '0;

    // drop the result once the sink takes it
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (op_e'(in_i.operation))
            OP_WALL: begin
              wm_we    = 1'b1;
              wm_waddr = CW'(in_i.cell_index);
              wm_wdata = in_i.wall_bit;
            end
            OP_RUN: begin
              start_d = in_i.start_cell;
              goal_d  = in_i.goal_cell;
              state_d = S_CHK;
            end
            OP_READ: begin
              cm_re    = 1'b1;
              cm_raddr = CW'(in_i.cell_index);
              state_d  = S_READ;
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        res_status_d  = ST_COST;
        res_reached_d = (cm_rd_q[COST_W-1:0] != COST_UNREACHED);
        res_cost_d    = res_reached_d ? cm_rd_q[OUT_COST_W-1:0] : '0;
        state_d       = S_RES;
      end

      // Argument checks: dimensions, cell range, then the two wall bits.
      S_CHK: begin
        n_d = IW'(rows_q) * IW'(cols_q);
        if (rows_q == '0 || cols_q == '0 ||
            32'(rows_q) > MAX_ROWS || 32'(cols_q) > MAX_COLS) begin
          res_status_d  = ST_INVALID;
          res_cost_d    = '0;
          res_reached_d = 1'b0;
          state_d       = S_RES;
        end else begin
          state_d = S_CHK2;
        end
      end

      S_CHK2: begin
        if (IW'(start_q) >= n_q || IW'(goal_q) >= n_q) begin
          res_status_d  = ST_INVALID;
          res_cost_d    = '0;
          res_reached_d = 1'b0;
          state_d       = S_RES;
        end else begin
          wm_re    = 1'b1;
          wm_raddr = CW'(start_q);
          state_d  = S_WG;
        end
      end

      S_WG: begin
        if (wm_rd_q) begin
          res_status_d  = ST_INVALID;
          res_cost_d    = '0;
          res_reached_d = 1'b0;
          state_d       = S_RES;
        end else begin
          wm_re    = 1'b1;
          wm_raddr = CW'(goal_q);
          state_d  = S_WC;
        end
      end

      S_WC: begin
        if (wm_rd_q) begin
          res_status_d  = ST_INVALID;
          res_cost_d    = '0;
          res_reached_d = 1'b0;
          state_d       = S_RES;
        end else begin
          i_d     = '0;
          r_d     = '0;
          c_d     = '0;
          len_d   = '0;
          state_d = S_CLR;
        end
      end

      // Sweep the cells in use; pick up start and goal coordinates on the way.
      S_CLR: begin
        cm_we    = 1'b1;
        cm_waddr = i_q;
        cm_wdata = {1'b0, COST_UNREACHED};
        if (i_q == CW'(start_q)) begin
          sr_d = r_q;
          sc_d = c_q;
        end
        if (i_q == CW'(goal_q)) begin
          gr_d = r_q;
          gc_d = c_q;
        end
        if ((CW2'(c_q) + CW2'(1)) == CW2'(cols_q)) begin
          c_d = '0;
          r_d = r_q + RW'(1);
        end else begin
          c_d = c_q + CLW'(1);
        end
        i_d = i_q + CW'(1);
        if ((IW'(i_q) + IW'(1)) == n_q) state_d = S_INIT;
      end

      S_INIT: begin
        cm_we     = 1'b1;
        cm_waddr  = CW'(start_q);
        cm_wdata  = '0;
        key_d.f   = F_W'(heur(sr_q, sc_q, gr_q, gc_q));
        key_d.v   = CW'(start_q);
        key_d.r   = sr_q;
        key_d.c   = sc_q;
        pos_d     = '0;
        len_d     = LW'(1);
        from_nb_d = 1'b0;
        state_d   = S_PUSH_UP;
      end

      // Heap insertion: climb while the parent key is larger.
      S_PUSH_UP: begin
        if (pos_q == '0) begin
          hp_we    = 1'b1;
          hp_waddr = '0;
          hp_wdata = key_q;
          state_d  = from_nb_q ? S_NEXT : S_LOOP;
        end else begin
          hp_re    = 1'b1;
          hp_raddr = up_idx[HA-1:0];
          up_d     = up_idx;
          state_d  = S_PUSH_CMP;
        end
      end

      S_PUSH_CMP: begin
        hp_we    = 1'b1;
        hp_waddr = pos_q[HA-1:0];
        if (key_le(hp_rd_q, key_q)) begin
          hp_wdata = key_q;
          state_d  = from_nb_q ? S_NEXT : S_LOOP;
        end else begin
          hp_wdata = hp_rd_q;
          pos_d    = up_q;
          state_d  = S_PUSH_UP;
        end
      end

      S_LOOP: begin
        if (len_q != '0) begin
          state_d = S_POP0;
        end else begin
          res_status_d  = ST_NO_PATH;
          res_cost_d    = '0;
          res_reached_d = 1'b0;
          state_d       = S_RES;
        end
      end

      // Heap removal: take the root, move the last entry down.
      S_POP0: begin
        hp_re    = 1'b1;
        hp_raddr = '0;
        state_d  = S_POP1;
      end

      S_POP1: begin
        top_d    = hp_rd_q;
        hp_re    = 1'b1;
        hp_raddr = len_m1[HA-1:0];
        len_d    = len_m1;
        state_d  = S_POP2;
      end

      S_POP2: begin
        last_d  = hp_rd_q;
        pos_d   = '0;
        state_d = S_POP_DN;
      end

      S_POP_DN: begin
        if (kid_first >= KW'(len_q)) begin
          state_d = S_POP_END;
        end else begin
          hp_re    = 1'b1;
          hp_raddr = kid_first[HA-1:0];
          kid_d    = kid_first;
          state_d  = S_POP_K1;
        end
      end

      S_POP_K1: begin
        best_d = hp_rd_q;
        if (kid_next < KW'(len_q)) begin
          hp_re    = 1'b1;
          hp_raddr = kid_next[HA-1:0];
          state_d  = S_POP_K2;
        end else begin
          state_d = S_POP_CMP;
        end
      end

      S_POP_K2: begin
        if (key_lt(hp_rd_q, best_q)) begin
          best_d = hp_rd_q;
          kid_d  = kid_next;
        end
        state_d = S_POP_CMP;
      end

      S_POP_CMP: begin
        if (key_le(last_q, best_q)) begin
          state_d = S_POP_END;
        end else begin
          hp_we    = 1'b1;
          hp_waddr = pos_q[HA-1:0];
          hp_wdata = best_q;
          pos_d    = kid_q[LW-1:0];
          state_d  = S_POP_DN;
        end
      end

      S_POP_END: begin
        if (len_q != '0) begin
          hp_we    = 1'b1;
          hp_waddr = pos_q[HA-1:0];
          hp_wdata = last_q;
        end
        state_d = S_EX0;
      end

      // Examine the popped cell: skip closed or outdated entries.
      S_EX0: begin
        cm_re    = 1'b1;
        cm_raddr = top_q.v;
        state_d  = S_EX1;
      end

      S_EX1: begin
        if (stale) begin
          state_d = S_LOOP;
        end else if (top_q.v == CW'(goal_q)) begin
          res_status_d  = ST_FOUND;
          res_cost_d    = cm_rd_q[OUT_COST_W-1:0];
          res_reached_d = 1'b1;
          state_d       = S_RES;
        end else begin
          cm_we    = 1'b1;
          cm_waddr = top_q.v;
          cm_wdata = {1'b1, cm_rd_q[COST_W-1:0]};
          g_d      = cm_rd_q[COST_W-1:0];
          nb_d     = NB_UP;
          state_d  = S_NB0;
        end
      end

      // Relax one neighbour: read its wall and cost, then write and insert.
      S_NB0: begin
        if (nb_ok) begin
          wm_re    = 1'b1;
          wm_raddr = nb_v;
          cm_re    = 1'b1;
          cm_raddr = nb_v;
          x_d      = nb_v;
          xr_d     = nb_r;
          xc_d     = nb_c;
          state_d  = S_NB1;
        end else begin
          state_d = S_NEXT;
        end
      end

      S_NB1: begin
        state_d = S_NEXT;
        if (!wm_rd_q && !cm_rd_q[COST_W] && (g_inc < cm_rd_q[COST_W-1:0])) begin
          cm_we    = 1'b1;
          cm_waddr = x_q;
          cm_wdata = {1'b0, g_inc};
          if (len_q < LW'(SLOTS)) begin
            key_d.f   = F_W'(g_inc) + F_W'(heur(xr_q, xc_q, gr_q, gc_q));
            key_d.v   = x_q;
            key_d.r   = xr_q;
            key_d.c   = xc_q;
            pos_d     = len_q;
            len_d     = len_q + LW'(1);
            from_nb_d = 1'b1;
            state_d   = S_PUSH_UP;
          end
        end
      end

      S_NEXT: begin
        if (nb_q == NB_RIGHT) begin
          state_d = S_LOOP;
        end else begin
          nb_d    = nb_e'(nb_q + 2'd1);
          state_d = S_NB0;
        end
      end

      // Hand the result to the output register once it is free.
      S_RES: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_cost_d    = res_cost_q;
          out_reached_d = res_reached_q;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      start_q       <= '0;
      goal_q        <= '0;
      n_q           <= '0;
      i_q           <= '0;
      r_q           <= '0;
      c_q           <= '0;
      sr_q          <= '0;
      sc_q          <= '0;
      gr_q          <= '0;
      gc_q          <= '0;
      xr_q          <= '0;
      xc_q          <= '0;
      x_q           <= '0;
      len_q         <= '0;
      pos_q         <= '0;
      up_q          <= '0;
      kid_q         <= '0;
      key_q         <= '0;
      best_q        <= '0;
      top_q         <= '0;
      last_q        <= '0;
      from_nb_q     <= 1'b0;
      g_q           <= '0;
      nb_q          <= NB_UP;
      res_status_q  <= ST_FOUND;
      res_cost_q    <= '0;
      res_reached_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_FOUND;
      out_cost_q    <= '0;
      out_reached_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      start_q       <= start_d;
      goal_q        <= goal_d;
      n_q           <= n_d;
      i_q           <= i_d;
      r_q           <= r_d;
      c_q           <= c_d;
      sr_q          <= sr_d;
      sc_q          <= sc_d;
      gr_q          <= gr_d;
      gc_q          <= gc_d;
      xr_q          <= xr_d;
      xc_q          <= xc_d;
      x_q           <= x_d;
      len_q         <= len_d;
      pos_q         <= pos_d;
      up_q          <= up_d;
      kid_q         <= kid_d;
      key_q         <= key_d;
      best_q        <= best_d;
      top_q         <= top_d;
      last_q        <= last_d;
      from_nb_q     <= from_nb_d;
      g_q           <= g_d;
      nb_q          <= nb_d;
      res_status_q  <= res_status_d;
      res_cost_q    <= res_cost_d;
      res_reached_q <= res_reached_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_cost_q    <= out_cost_d;
      out_reached_q <= out_reached_d;
    end
  end

  // Channel outputs
  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.cost    = out_cost_q;
  assign out_o.reached = out_reached_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LW'(SLOTS))
    else $error("open-list heap holds more entries than it has slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_CLR) |-> (IW'(i_q) < n_q))
    else $error("cost sweep ran past the cells in use");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_POP_K1) |-> (kid_q < KW'(len_q)))
    else $error("heap sift-down read a child beyond the heap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_NB1) |-> ($past(state_q) == S_NB0))
    else $error("neighbour relax step entered without its memory read");

endmodule
